### design/kt_pkg.sv
`default_nettype none
package kt_pkg;

  localparam int OP_W       = 2;
  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int ST_W       = 3;
  localparam int SLOT_W     = 6;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  typedef logic [OP_W-1:0]  opcode_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] value_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_REMOVE = 2'd1;
  localparam opcode_t OP_LOOKUP = 2'd2;

  localparam status_t ST_DONE  = 3'd0;
  localparam status_t ST_DUP   = 3'd1;
  localparam status_t ST_FULL  = 3'd2;
  localparam status_t ST_MISS  = 3'd3;
  localparam status_t ST_EMPTY = 3'd4;

endpackage
`default_nettype wire

### design/keyed_table_insert_remove_lookup.sv
// Channel  Direction  tuser            tdata
// in_      slave      opcode[1:0]      key[30:0], value_in[62:31], zero[63]
// out_     master     status[2:0]      value_out[31:0], slot[37:32], zero[39:38]
//
// One item at a time: an accepted item is scanned against the key/value memories at
// one read per cycle over the slots below the fill count; the finish state then
// loads the result and does any write-back. Full, empty and unused opcodes do not
// wait for the scan. Synchronous active-low reset clears the fill count and control;
// no clearing pass, since only slots below the fill count are read.
// A stalled result holds in the output register; the next item is accepted meanwhile.
`default_nettype none
module keyed_table_insert_remove_lookup #(
  parameter int CAPACITY = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output      logic                         in_tready,
  input  wire logic [kt_pkg::IN_DATA_W-1:0] in_tdata,  // key, value_in, zero pad
  input  wire logic [kt_pkg::OP_W-1:0]      in_tuser,  // opcode
  output      logic                         out_tvalid,
  input  wire logic                         out_tready,
  output      logic [kt_pkg::OUT_DATA_W-1:0] out_tdata, // value_out, slot, zero pad
  output      logic [kt_pkg::ST_W-1:0]      out_tuser  // status
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int KW     = kt_pkg::KEY_W;
  localparam int VW     = kt_pkg::VAL_W;
  localparam int SW     = kt_pkg::SLOT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        fill_count_r;
  logic [CNT_W-1:0]        scan_cnt_r;
  kt_pkg::opcode_t         op_r;
  kt_pkg::key_t            key_r;
  kt_pkg::value_t          val_r;
  logic                    early_r;
  kt_pkg::status_t         early_st_r;

  logic                    rd_vld_r;
  logic [ADDR_W-1:0]       rd_idx_r;
  logic [KW:0]             kmem_rd_r;
  kt_pkg::value_t          vmem_rd_r;

  logic                    vhit_r, dhit_r;
  logic [ADDR_W-1:0]       vidx_r, didx_r;
  kt_pkg::value_t          vval_r;

  logic                    out_valid_r;
  kt_pkg::status_t         out_status_r;
  kt_pkg::value_t          out_value_r;
  logic [SW-1:0]           out_slot_r;

  logic [KW:0]             key_mem [CAPACITY];
  kt_pkg::value_t          val_mem [CAPACITY];

  logic                    accept;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    fin_go;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [KW:0]             wr_kdata;
  logic                    wr_val;
  logic                    fill_inc;
  kt_pkg::status_t         res_status;
  kt_pkg::value_t          res_value;
  logic [ADDR_W-1:0]       res_idx;
  logic [ADDR_W+SW-1:0]    res_idx_ext;
  logic                    key_eq;
  logic                    is_full, is_empty;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign is_full   = (fill_count_r >= CNT_W'(CAPACITY));
  assign is_empty  = (fill_count_r == '0);

  assign rd_en   = (state_r == S_SCAN) && (scan_cnt_r < fill_count_r);
  assign rd_addr = scan_cnt_r[ADDR_W-1:0];
  assign key_eq  = (kmem_rd_r[KW-1:0] == key_r);
  assign fin_go  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_kdata;
    end
    if (rd_en) begin
      kmem_rd_r <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_val) begin
      val_mem[wr_addr] <= val_r;
    end
    if (rd_en) begin
      vmem_rd_r <= val_mem[rd_addr];
    end
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_val     = 1'b0;
    wr_addr    = fill_count_r[ADDR_W-1:0];
    wr_kdata   = {1'b1, key_r};
    fill_inc   = 1'b0;
    res_status = kt_pkg::ST_MISS;
    res_value  = '0;
    res_idx    = '0;
    priority if (early_r) begin
      res_status = early_st_r;
    end else if (op_r == kt_pkg::OP_INSERT) begin
      priority if (vhit_r) begin
        res_status = kt_pkg::ST_DUP;
      end else if (dhit_r) begin
        res_status = kt_pkg::ST_DONE;
        res_idx    = didx_r;
        wr_addr    = didx_r;
        wr_en      = fin_go;
        wr_val     = fin_go;
      end else begin
        res_status = kt_pkg::ST_DONE;
        res_idx    = fill_count_r[ADDR_W-1:0];
        wr_en      = fin_go;
        wr_val     = fin_go;
        fill_inc   = fin_go;
      end
    end else if (vhit_r) begin
      res_status = kt_pkg::ST_DONE;
      res_idx    = vidx_r;
      wr_addr    = vidx_r;
      wr_kdata   = {1'b0, key_r};
      if (op_r == kt_pkg::OP_REMOVE) begin
        wr_en = fin_go;
      end else begin
        res_value = vval_r;
      end
    end else begin
      res_status = kt_pkg::ST_MISS;
    end
  end

  assign res_idx_ext = {{SW{1'b0}}, res_idx};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (early_r || (!rd_en && !rd_vld_r)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_count_r <= '0;
      scan_cnt_r   <= '0;
      rd_vld_r     <= 1'b0;
      vhit_r       <= 1'b0;
      dhit_r       <= 1'b0;
      early_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en && !early_r;
      if (fill_inc) begin
        fill_count_r <= fill_count_r + CNT_W'(1);
      end
      if (accept) begin
        scan_cnt_r <= '0;
        vhit_r     <= 1'b0;
        dhit_r     <= 1'b0;
        early_r    <= ((in_tuser == kt_pkg::OP_INSERT) && is_full)
                   || ((in_tuser == kt_pkg::OP_REMOVE || in_tuser == kt_pkg::OP_LOOKUP)
                       && is_empty)
                   || !(in_tuser == kt_pkg::OP_INSERT || in_tuser == kt_pkg::OP_REMOVE
                        || in_tuser == kt_pkg::OP_LOOKUP);
      end else begin
        if (rd_en) begin
          scan_cnt_r <= scan_cnt_r + CNT_W'(1);
        end
        // keep the first match of each kind
        if (rd_vld_r && key_eq) begin
          if (kmem_rd_r[KW] && !vhit_r) begin
            vhit_r <= 1'b1;
          end
          if (!kmem_rd_r[KW] && !dhit_r) begin
            dhit_r <= 1'b1;
          end
        end
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tuser;
      key_r <= in_tdata[KW-1:0];
      val_r <= in_tdata[KW+VW-1:KW];
      priority if (in_tuser == kt_pkg::OP_INSERT) begin
        early_st_r <= kt_pkg::ST_FULL;
      end else if ((in_tuser == kt_pkg::OP_REMOVE || in_tuser == kt_pkg::OP_LOOKUP)
                   && is_empty) begin
        early_st_r <= kt_pkg::ST_EMPTY;
      end else begin
        early_st_r <= kt_pkg::ST_MISS;
      end
    end
    if (rd_en) begin
      rd_idx_r <= rd_addr;
    end
    if (rd_vld_r && key_eq && kmem_rd_r[KW] && !vhit_r) begin
      vidx_r <= rd_idx_r;
      vval_r <= vmem_rd_r;
    end
    if (rd_vld_r && key_eq && !kmem_rd_r[KW] && !dhit_r) begin
      didx_r <= rd_idx_r;
    end
    if (fin_go) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
      out_slot_r   <= res_idx_ext[SW-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(kt_pkg::OUT_DATA_W - VW - SW){1'b0}}, out_slot_r, out_value_r};

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (fill_count_r != $past(fill_count_r)))
      |-> (fill_count_r == $past(fill_count_r) + CNT_W'(1)))
    else $error("fill count moved by other than one");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && !early_r && (op_r == kt_pkg::OP_INSERT) && !vhit_r && !dhit_r)
      |=> (fill_count_r == $past(fill_count_r) + CNT_W'(1)))
    else $error("append did not grow the table");

  a_hit_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
    vhit_r |-> (CNT_W'(vidx_r) < fill_count_r))
    else $error("match index at or above fill count");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_cnt_r <= fill_count_r))
    else $error("scan counter ran past fill count");

endmodule
`default_nettype wire
